@@ src/npr_pkg.sv @@
// Package for the nonlinear phase rotation block.
// Holds the CORDIC vector type, the arctangent table and the register map.
// Used by npr_cordic_stage and nonlinear_phase_rotation.
package npr_pkg;

    // Internal CORDIC datapath width; the vector stays below 2^31 in magnitude.
    localparam int unsigned CORDIC_W = 34;
    localparam int unsigned GAIN_W   = 32;
    localparam int unsigned PHASE_W  = 16;
    localparam int unsigned PROD_W   = 52;
    localparam int unsigned PADDR_W  = 3;

    // Register indexes, taken from paddr[PADDR_W-1:2].
    localparam logic [PADDR_W-3:0] REG_PHASE_GAIN = '0;

    // Starting x in Q.30: the reciprocal of the CORDIC gain for an unbounded stage count.
    localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;

    // Rounding constant that turns the Q.52 turn product into a 16-bit phase.
    localparam logic [PROD_W-1:0] PHASE_ROUND = 52'h0_0008_0000_0000;

    localparam int unsigned ATAN_ENTRIES = 24;

    // Arctangent of 2^-i, in 32-bit turns.
    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
        logic [1:0]                 quad;
    } t_cordic;

    function automatic logic signed [CORDIC_W-1:0] atan_at(input int unsigned idx);
        int unsigned sel;
        sel = (idx < ATAN_ENTRIES) ? idx : ATAN_ENTRIES - 1;
        return $signed({{(CORDIC_W-32){1'b0}}, ATAN_TURNS[sel]});
    endfunction

endpackage

@@ src/npr_cordic_stage.sv @@
// One registered CORDIC rotation step for the nonlinear phase rotation block.
// Depends on npr_pkg for the vector type and the arctangent table.
module npr_cordic_stage #(
    parameter int unsigned STAGE = 0
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  npr_pkg::t_cordic i_vec,
    output npr_pkg::t_cordic o_vec
);

    localparam logic signed [npr_pkg::CORDIC_W-1:0] ANGLE = npr_pkg::atan_at(STAGE);

    npr_pkg::t_cordic n_vec;
    npr_pkg::t_cordic r_vec;

    always_comb begin
        n_vec      = i_vec;
        // Rotate toward zero residual angle; shifts are arithmetic (floor).
        if (!i_vec.z[npr_pkg::CORDIC_W-1]) begin
            n_vec.x = i_vec.x - (i_vec.y >>> STAGE);
            n_vec.y = i_vec.y + (i_vec.x >>> STAGE);
            n_vec.z = i_vec.z - ANGLE;
        end else begin
            n_vec.x = i_vec.x + (i_vec.y >>> STAGE);
            n_vec.y = i_vec.y - (i_vec.x >>> STAGE);
            n_vec.z = i_vec.z + ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

@@ src/nonlinear_phase_rotation.sv @@
// Top level of the nonlinear phase rotation block: out = v * exp(i*2*pi*|v|^2*gain).
// Depends on npr_pkg and npr_cordic_stage.
//
// Usage:
//   Samples enter on the s_axis stream, one word per cycle while s_axis_tready
//   is high; s_axis_tdata holds re_in in the low SAMPLE_WIDTH bits and im_in
//   above it. Rotated samples leave on m_axis in the same packing. The phase
//   gain (signed Q8.24 turns) sits at APB address 0 and should only be written
//   while the pipeline is empty. A word passes ROTATION_STAGES + 6 registers,
//   the first of them loaded at the accepting edge: two squaring/sum stages,
//   one stage of gain partial products, one phase and quadrant stage, one stage
//   per CORDIC rotation, one stage of complex products and the rounding/saturation
//   output register. Throughput is one word per cycle while the output is not
//   stalled by m_axis_tready.
//   Every stage has its own valid bit and loads whenever it is empty or the
//   stage after it moves, so a stalled output only halts the words behind it
//   and empty slots are filled while the output waits.
//   Reset clears all valid bits and the gain register (no rotation).
module nonlinear_phase_rotation #(
    parameter int unsigned SAMPLE_WIDTH    = 18,
    parameter int unsigned ROTATION_STAGES = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input stream; tdata: re_in, im_in (from bit 0 up), zero padded to bytes.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // Output stream; tdata: re_out, im_out (from bit 0 up), zero padded to bytes.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    // Configuration port.
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [npr_pkg::PADDR_W-1:0]            paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int unsigned SW     = SAMPLE_WIDTH;
    localparam int unsigned R      = ROTATION_STAGES;
    localparam int unsigned DATA_W = ((2*SW+7)/8)*8;
    localparam int unsigned CW     = npr_pkg::CORDIC_W;
    localparam int unsigned PW     = SW + CW;
    localparam int unsigned NS     = R + 6;
    localparam int unsigned NRE    = R + 4;
    localparam int unsigned ST_CIN = 3;
    localparam int unsigned ST_MUL = R + 4;

    localparam logic signed [PW:0] PROD_ROUND = (PW+1)'(64'd1 << 29);
    localparam logic signed [PW:0] SAT_HI     = {{(PW-SW+2){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [PW:0] SAT_LO     = ~SAT_HI;

    localparam logic signed [CW-1:0] EIGHTH_TURN = CW'(64'd1 << 29);

    function automatic logic [SW-1:0] f_sat(input logic signed [PW:0] v);
        logic signed [PW:0] t;
        t = v;
        if (v > SAT_HI) begin
            t = SAT_HI;
        end else if (v < SAT_LO) begin
            t = SAT_LO;
        end
        return t[SW-1:0];
    endfunction

    // ---------------- configuration ----------------
    logic signed [npr_pkg::GAIN_W-1:0] r_gain;
    logic                              w_reg_hit;

    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[npr_pkg::PADDR_W-1:2] == npr_pkg::REG_PHASE_GAIN);
    assign prdata    = w_reg_hit ? r_gain : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= '0;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_gain <= pwdata;
        end
    end

    // ---------------- stage flow control ----------------
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] w_en;

    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign n_vld         = {r_vld[NS-2:0], s_axis_tvalid};
    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // ---------------- sample delay line ----------------
    logic signed [SW-1:0] w_re_in;
    logic signed [SW-1:0] w_im_in;
    logic signed [SW-1:0] r_re [NRE];
    logic signed [SW-1:0] r_im [NRE];

    assign w_re_in = s_axis_tdata[SW-1:0];
    assign w_im_in = s_axis_tdata[2*SW-1:SW];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_re[0] <= w_re_in;
            r_im[0] <= w_im_in;
        end
        for (int k = 1; k < NRE; k++) begin
            if (w_en[k]) begin
                r_re[k] <= r_re[k-1];
                r_im[k] <= r_im[k-1];
            end
        end
    end

    // ---------------- stages 0 and 1: squared magnitude ----------------
    logic signed [2*SW-1:0] w_re2;
    logic signed [2*SW-1:0] w_im2;
    logic [2*SW-1:0]        r_re2;
    logic [2*SW-1:0]        r_im2;
    logic [2*SW-1:0]        r_mag2;

    assign w_re2 = w_re_in * w_re_in;
    assign w_im2 = w_im_in * w_im_in;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_re2 <= w_re2;
            r_im2 <= w_im2;
        end
        if (w_en[1]) begin
            r_mag2 <= r_re2 + r_im2;
        end
    end

    // ---------------- stage 2: gain partial products ----------------
    // Only the product modulo 2^52 reaches the phase, so the magnitude is
    // split into two 26-bit halves and the upper half keeps 26 bits.
    logic [63:0]        w_mag64;
    logic signed [58:0] w_pl_full;
    logic signed [58:0] w_ph_full;
    logic [51:0]        r_pl;
    logic [25:0]        r_ph;

    assign w_mag64   = 64'(r_mag2);
    assign w_pl_full = $signed({1'b0, w_mag64[25:0]}) * r_gain;
    assign w_ph_full = $signed({1'b0, w_mag64[51:26]}) * r_gain;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_pl <= w_pl_full[51:0];
            r_ph <= w_ph_full[25:0];
        end
    end

    // ---------------- stage 3: phase, quadrant and residue ----------------
    logic [npr_pkg::PROD_W-1:0]  w_sum52;
    logic [npr_pkg::PHASE_W-1:0] w_phase;
    logic [npr_pkg::PHASE_W-1:0] w_phase_q;
    logic [1:0]                  w_quad;
    logic [31:0]                 w_z32;
    npr_pkg::t_cordic            n_cin;
    npr_pkg::t_cordic            r_cin;

    assign w_sum52   = r_pl + {r_ph, 26'b0} + npr_pkg::PHASE_ROUND;
    assign w_phase   = w_sum52[51:36];
    assign w_phase_q = w_phase + 16'h2000;
    assign w_quad    = w_phase_q[15:14];
    assign w_z32     = {w_phase, 16'b0} - {w_quad, 30'b0};

    always_comb begin
        n_cin.x    = npr_pkg::CORDIC_START;
        n_cin.y    = '0;
        n_cin.z    = CW'($signed(w_z32));
        n_cin.quad = w_quad;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_CIN]) begin
            r_cin <= n_cin;
        end
    end

    // ---------------- CORDIC rotation stages ----------------
    npr_pkg::t_cordic w_vec [R+1];

    assign w_vec[0] = r_cin;

    for (genvar g = 0; g < R; g++) begin : g_rot
        npr_cordic_stage #(
            .STAGE (g)
        ) u_stage (
            .i_clk (i_clk),
            .i_en  (w_en[ST_CIN+1+g]),
            .i_vec (w_vec[g]),
            .o_vec (w_vec[g+1])
        );
    end

    // ---------------- quadrant turn and complex products ----------------
    logic signed [CW-1:0] w_cos;
    logic signed [CW-1:0] w_sin;
    logic signed [PW-1:0] r_rc;
    logic signed [PW-1:0] r_is;
    logic signed [PW-1:0] r_rs;
    logic signed [PW-1:0] r_ic;

    always_comb begin
        unique case (w_vec[R].quad)
            2'd0: begin
                w_cos = w_vec[R].x;
                w_sin = w_vec[R].y;
            end
            2'd1: begin
                w_cos = -w_vec[R].y;
                w_sin = w_vec[R].x;
            end
            2'd2: begin
                w_cos = -w_vec[R].x;
                w_sin = -w_vec[R].y;
            end
            default: begin
                w_cos = w_vec[R].y;
                w_sin = -w_vec[R].x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_MUL]) begin
            r_rc <= r_re[NRE-1] * w_cos;
            r_is <= r_im[NRE-1] * w_sin;
            r_rs <= r_re[NRE-1] * w_sin;
            r_ic <= r_im[NRE-1] * w_cos;
        end
    end

    // ---------------- output register: round and saturate ----------------
    logic signed [PW:0] w_sum_re;
    logic signed [PW:0] w_sum_im;
    logic [SW-1:0]      r_re_out;
    logic [SW-1:0]      r_im_out;

    assign w_sum_re = $signed({r_rc[PW-1], r_rc}) - $signed({r_is[PW-1], r_is}) + PROD_ROUND;
    assign w_sum_im = $signed({r_rs[PW-1], r_rs}) + $signed({r_ic[PW-1], r_ic}) + PROD_ROUND;

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_re_out <= f_sat(w_sum_re >>> 30);
            r_im_out <= f_sat(w_sum_im >>> 30);
        end
    end

    assign m_axis_tdata = DATA_W'({r_im_out, r_re_out});

    // ---------------- assertions ----------------
    // Out of reset the pipeline holds no word.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // A full pipeline facing a stalled receiver must not take a new word.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !m_axis_tready) |-> !s_axis_tready)
        else $error("word accepted into a full, stalled pipeline");

    // After quadrant reduction the residual angle lies within one eighth turn.
    a_residue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_CIN] |-> (r_cin.z >= -EIGHTH_TURN) && (r_cin.z < EIGHTH_TURN))
        else $error("CORDIC residue outside one eighth turn");

endmodule

@@ tb/nonlinear_phase_rotation_tb.sv @@
// Self-checking testbench for nonlinear_phase_rotation: streams complex samples,
// predicts each rotated word in fixed point and compares both parts per word.
// Depends on npr_pkg and the RTL of the block; needs nothing else.
module nonlinear_phase_rotation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW          = 18;
    localparam int STAGES      = 16;
    localparam int DATA_W      = ((2*SW+7)/8)*8;
    localparam int PAD_W       = DATA_W - 2*SW;
    localparam int LATENCY     = STAGES + 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 2000;
    localparam int RAND_SETS   = 8;

    localparam longint SAMPLE_MAX = (64'sd1 <<< (SW-1)) - 1;
    localparam longint SAMPLE_MIN = -(64'sd1 <<< (SW-1));
    localparam longint unsigned TURN_HALF_LSB = 64'h0000_0008_0000_0000;
    localparam longint ROT_START = 64'sd652032874;

    localparam logic [npr_pkg::PADDR_W-1:0] ADDR_GAIN   = {npr_pkg::REG_PHASE_GAIN, 2'b00};
    localparam logic [npr_pkg::PADDR_W-1:0] ADDR_UNUSED = ADDR_GAIN + 3'd4;

    // Arctangent of 2^-i in 32-bit turns; the last entry repeats for deeper stages.
    localparam longint ATAN_STEP [24] = '{
        'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
        'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051
    };

    typedef struct packed {
        logic signed [SW-1:0] re;
        logic signed [SW-1:0] im;
    } t_sample;

    typedef enum int {SINK_ALWAYS, SINK_PERIODIC, SINK_RANDOM} t_sink_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // tdata: re_in [17:0], im_in [35:18], zero pad above.
    logic [DATA_W-1:0] s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // tdata: re_out [17:0], im_out [35:18], zero pad above.
    logic [DATA_W-1:0] m_axis_tdata;

    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [npr_pkg::PADDR_W-1:0] paddr   = '0;
    logic [31:0]                 pwdata  = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    nonlinear_phase_rotation #(
        .SAMPLE_WIDTH   (SW),
        .ROTATION_STAGES(STAGES)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    t_sample            rotated_q[$];
    logic signed [31:0] gain_shadow = '0;
    int                 mismatches = 0;
    int                 words_sent = 0;
    int                 words_checked = 0;
    int                 gain_writes = 0;
    int                 cycle_count = 0;
    int                 burst_left = 0;
    bit                 feed_gaps = 1'b0;
    t_sink_mode         sink_mode = SINK_ALWAYS;
    int                 sink_period = 4;
    int                 sink_duty = 2;
    int                 sink_tick = 0;

    initial forever #5 i_clk = ~i_clk;

    // Cosine and sine of a 16-bit turn phase, Q.30, through the shift-add rotator.
    function automatic void phase_cos_sin(input logic [15:0] phase,
                                          output longint c, output longint s);
        logic [31:0] ang;
        logic [31:0] resid;
        logic [1:0]  quad;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        longint      step;
        ang   = {phase, 16'h0000};
        quad  = 2'((ang + 32'h2000_0000) >> 30);
        resid = ang - {quad, 30'h0};
        z     = longint'($signed(resid));
        x     = ROT_START;
        y     = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx   = y >>> i;
            dy   = x >>> i;
            step = ATAN_STEP[(i < 24) ? i : 23];
            if (z >= 0) begin
                x -= dx; y += dy; z -= step;
            end else begin
                x += dx; y -= dy; z += step;
            end
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic logic signed [SW-1:0] clamp_sample(input longint v);
        if (v > SAMPLE_MAX) return SW'(SAMPLE_MAX);
        if (v < SAMPLE_MIN) return SW'(SAMPLE_MIN);
        return SW'(v);
    endfunction

    function automatic t_sample rotate_sample(input logic signed [SW-1:0] re,
                                              input logic signed [SW-1:0] im,
                                              input logic signed [31:0] gain);
        longint          r;
        longint          m;
        longint          c;
        longint          s;
        longint unsigned turns;
        logic [15:0]     phase;
        t_sample         res;
        r     = re;
        m     = im;
        // The product wraps modulo 2^64, which drops whole turns.
        turns = longint'(r*r + m*m) * longint'(gain);
        phase = 16'((turns + TURN_HALF_LSB) >> 36);
        phase_cos_sin(phase, c, s);
        res.re = clamp_sample((r*c - m*s + (64'sd1 <<< 29)) >>> 30);
        res.im = clamp_sample((r*s + m*c + (64'sd1 <<< 29)) >>> 30);
        return res;
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, rotated_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        sink_tick <= sink_tick + 1;
        case (sink_mode)
            SINK_ALWAYS:   m_axis_tready <= 1'b1;
            SINK_PERIODIC: m_axis_tready <= (sink_tick % sink_period) < sink_duty;
            default:       m_axis_tready <= ($urandom_range(0, 99) < 60);
        endcase
    end

    always @(posedge i_clk) begin
        t_sample want;
        t_sample got;
        if (m_axis_tvalid && m_axis_tready) begin
            got.re = m_axis_tdata[SW-1:0];
            got.im = m_axis_tdata[2*SW-1:SW];
            if (rotated_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word re=%0d im=%0d", got.re, got.im);
            end else begin
                want = rotated_q.pop_front();
                words_checked++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: expected re=%0d im=%0d, got re=%0d im=%0d",
                                 words_checked - 1, want.re, want.im, got.re, got.im);
                end
            end
        end
    end

    task automatic send_sample(input logic signed [SW-1:0] re,
                               input logic signed [SW-1:0] im,
                               input logic [PAD_W-1:0] pad = '0);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (feed_gaps) begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pad, im, re};
        do @(posedge i_clk); while (!s_axis_tready);
        rotated_q.push_back(rotate_sample(re, im, gain_shadow));
        words_sent++;
    endtask

    // Stops the feed and waits until every predicted word has come out.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (rotated_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [npr_pkg::PADDR_W-1:0] addr,
                             input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[npr_pkg::PADDR_W-1:2] == npr_pkg::REG_PHASE_GAIN) begin
            gain_shadow = data;
            gain_writes++;
        end
    endtask

    task automatic check_gain_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_GAIN;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== gain_shadow) begin
            mismatches++;
            if (mismatches <= 10)
                $display("gain readback: expected %h, got %h", gain_shadow, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_gain(input logic [31:0] gain);
        drain_pipeline();
        apb_write(ADDR_GAIN, gain);
        check_gain_readback();
    endtask

    // Zero gain straight after reset: each sample passes through the rotator unturned.
    task automatic test_reset_passthrough();
        check_gain_readback();
        feed_gaps = 1'b0;
        sink_mode = SINK_ALWAYS;
        send_sample('0, '0);
        send_sample(SW'(SAMPLE_MAX), SW'(SAMPLE_MAX), '1);
        send_sample(SW'(SAMPLE_MIN), SW'(SAMPLE_MIN));
        send_sample(SW'(SAMPLE_MAX), SW'(SAMPLE_MIN), '1);
        send_sample(SW'(SAMPLE_MIN), SW'(SAMPLE_MAX));
        send_sample(SW'(1), SW'(-1));
    endtask

    // A write to an unmapped address must leave the gain alone; then each quadrant.
    task automatic test_quadrants();
        drain_pipeline();
        apb_write(ADDR_UNUSED, 32'h1234_5678);
        check_gain_readback();
        send_sample(SW'(16384), '0);
        set_gain(32'h0040_0000);
        send_sample(SW'(16384), '0);
        send_sample('0, SW'(-16384));
        set_gain(32'h0080_0000);
        send_sample(SW'(16384), '0);
        send_sample(SW'(11585), SW'(11585));
        set_gain(32'h00C0_0000);
        send_sample(SW'(16384), '0);
        send_sample(SW'(-16384), SW'(5000));
    endtask

    // Extreme gains, and a one-eighth turn on a full-scale sample that overflows.
    task automatic test_extremes_and_saturation();
        set_gain(32'h0000_4000);
        send_sample(SW'(SAMPLE_MAX), SW'(SAMPLE_MAX));
        send_sample(SW'(SAMPLE_MIN), SW'(SAMPLE_MIN));
        set_gain(32'h7FFF_FFFF);
        send_sample(SW'(SAMPLE_MAX), SW'(SAMPLE_MIN));
        send_sample(SW'(16384), SW'(16384));
        send_sample(SW'(1), '0);
        set_gain(32'h8000_0000);
        send_sample(SW'(SAMPLE_MIN), SW'(SAMPLE_MAX));
        send_sample(SW'(-16384), SW'(16384));
        send_sample('0, SW'(1));
    endtask

    function automatic logic signed [SW-1:0] pick_component();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return SW'($urandom);
        if (sel < 80) return SW'(int'($urandom_range(0, 32768)) - 16384);
        if (sel < 90) return $urandom_range(0, 1) ? SW'(SAMPLE_MAX) : SW'(SAMPLE_MIN);
        if (sel < 95) return SW'(1) <<< $urandom_range(0, SW-1);
        return '0;
    endfunction

    function automatic logic [31:0] pick_gain(input int set_idx);
        case (set_idx)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: begin
                if ($urandom_range(0, 1))
                    return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
                return $urandom;
            end
        endcase
    endfunction

    // Random samples over several gain settings and several feed and sink patterns.
    task automatic test_random_streams();
        int per_set;
        per_set = RAND_ITEMS / RAND_SETS;
        for (int k = 0; k < RAND_SETS; k++) begin
            set_gain(pick_gain(k));
            feed_gaps   = (k % 3) != 0;
            sink_mode   = t_sink_mode'(k % 3);
            sink_period = $urandom_range(2, 12);
            sink_duty   = $urandom_range(1, sink_period - 1);
            for (int n = 0; n < per_set; n++)
                send_sample(pick_component(), pick_component());
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_passthrough();
        test_quadrants();
        test_extremes_and_saturation();
        test_random_streams();
        drain_pipeline();
        repeat (LATENCY) @(posedge i_clk);

        $display("Sent %0d samples over %0d gain writes, %0d results checked.",
                 words_sent, gain_writes, words_checked);
        $display("Mismatches: %0d; outstanding at end: %0d.", mismatches, rotated_q.size());
        if (mismatches == 0 && rotated_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/npr_pkg.sv
src/npr_cordic_stage.sv
src/nonlinear_phase_rotation.sv
tb/nonlinear_phase_rotation_tb.sv
